>>> rtl/itx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itx_pkg
// Shared constants, opcodes and payload types of the I-type execute block.
// ----------------------------------------------------------------------------
package itx_pkg;

	localparam int MEM_DEPTH = 1024;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int NUM_REGS  = 32;
	localparam int REG_AW    = $clog2(NUM_REGS);

	localparam logic [3:0] OP_ADDI    = 4'd0;
	localparam logic [3:0] OP_XORI    = 4'd1;
	localparam logic [3:0] OP_ORI     = 4'd2;
	localparam logic [3:0] OP_ANDI    = 4'd3;
	localparam logic [3:0] OP_SLLI    = 4'd4;
	localparam logic [3:0] OP_SRLI    = 4'd5;
	localparam logic [3:0] OP_SRAI    = 4'd6;
	localparam logic [3:0] OP_SLTI    = 4'd7;
	localparam logic [3:0] OP_SLTIU   = 4'd8;
	localparam logic [3:0] OP_LW      = 4'd9;
	localparam logic [3:0] OP_LB      = 4'd10;
	localparam logic [3:0] OP_LBU     = 4'd11;
	localparam logic [3:0] OP_LH      = 4'd12;
	localparam logic [3:0] OP_LHU     = 4'd13;
	localparam logic [3:0] OP_JALR    = 4'd14;
	localparam logic [3:0] OP_PRELOAD = 4'd15;

	typedef struct packed {
		logic [3:0]        op;
		logic [4:0]        dest_reg;
		logic [4:0]        src_reg;
		logic signed [11:0] immediate;
		logic [31:0]       pc_in;
		logic [9:0]        preload_addr;
		logic [31:0]       preload_data;
	} instr_t;

	typedef struct packed {
		logic        wrote_reg;
		logic [4:0]  written_reg;
		logic [31:0] written_value;
		logic [31:0] pc_out;
		logic        mem_found;
	} result_t;

	// ALU stage outputs
	typedef struct packed {
		logic [31:0] value;
		logic [31:0] sum;
		logic [31:0] pc_next;
	} alu_out_t;

	// State carried from the ALU stage to the commit stage
	typedef struct packed {
		logic [3:0]  op;
		logic [4:0]  rd;
		logic [31:0] value;
		logic [31:0] pc_out;
		logic        in_range;
	} ctl_s2_t;

	function automatic logic is_load(input logic [3:0] op);
		return (op >= OP_LW) && (op <= OP_LHU);
	endfunction

endpackage
`default_nettype wire

>>> rtl/itx_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itx_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module itx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/itx_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itx_alu
// Immediate ALU: arithmetic, logic, shifts, compares, address and jump target.
// ----------------------------------------------------------------------------
module itx_alu import itx_pkg::*; (
	input  wire logic [3:0]         op,
	input  wire logic [31:0]        a,
	input  wire logic signed [11:0] imm,
	input  wire logic [31:0]        pc,
	output alu_out_t                res
);

	logic [31:0] imm32;
	logic [31:0] sum;
	logic [4:0]  sh;

	assign imm32 = 32'(imm);
	assign sum   = a + imm32;
	assign sh    = imm[4:0];

	always_comb begin
		res.sum     = sum;
		res.pc_next = pc;
		res.value   = '0;
		unique case (op)
			OP_ADDI:  res.value = sum;
			OP_XORI:  res.value = a ^ imm32;
			OP_ORI:   res.value = a | imm32;
			OP_ANDI:  res.value = a & imm32;
			OP_SLLI:  res.value = a << sh;
			OP_SRLI:  res.value = a >> sh;
			OP_SRAI:  res.value = 32'($signed(a) >>> sh);
			OP_SLTI:  res.value = {31'd0, $signed(a) < $signed(imm32)};
			OP_SLTIU: res.value = {31'd0, a < imm32};
			OP_JALR: begin
				res.value   = pc;
				res.pc_next = sum - 32'd4;
			end
			default:  res.value = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/itx_commit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itx_commit
// Final stage: load lookup, byte/halfword extension and register write decision.
// ----------------------------------------------------------------------------
module itx_commit import itx_pkg::*; (
	input  wire ctl_s2_t     ctl,
	input  wire logic [32:0] mem_rdata,
	output result_t          res
);

	logic        found;
	logic        wr;
	logic [31:0] word;
	logic [31:0] val;

	// top bit of a data word is its written flag
	assign found = is_load(ctl.op) && ctl.in_range && mem_rdata[32];
	assign word  = found ? mem_rdata[31:0] : 32'd0;

	always_comb begin
		unique case (ctl.op)
			OP_LW:   val = word;
			OP_LB:   val = {{24{word[7]}}, word[7:0]};
			OP_LBU:  val = {24'd0, word[7:0]};
			OP_LH:   val = {{16{word[15]}}, word[15:0]};
			OP_LHU:  val = {16'd0, word[15:0]};
			default: val = ctl.value;
		endcase
	end

	// x0 and preload never write; lw writes only on a hit
	assign wr = (ctl.rd != 5'd0) && (ctl.op != OP_PRELOAD) && ((ctl.op != OP_LW) || found);

	assign res.wrote_reg     = wr;
	assign res.written_reg   = wr ? ctl.rd : 5'd0;
	assign res.written_value = wr ? val : 32'd0;
	assign res.pc_out        = ctl.pc_out;
	assign res.mem_found     = found;

endmodule
`default_nettype wire

>>> rtl/rv32i_itype_execute.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32i_itype_execute
// RV32I I-type execute unit with register file and word data store.
// ----------------------------------------------------------------------------
// Usage:
//   instr channel: one I-type instruction or a data preload per transfer.
//   result channel: exactly one result per item, preloads too, in order.
//   Both channels transfer when valid is high and stall is low.
// Path: from instr transfer through stage 1, stage 2 and the result register.
// Throughput: one instruction per cycle unless stalled. Register file read at
//   transfer, ALU in stage 1 with forwarding from stage 2 and the last
//   writeback, data store read at the end of stage 1, commit in stage 2.
//   The data store has one read and one write port used at most once per item.
// Reset: the register file reads as zero (per-register valid flags). The
//   data store is then swept to clear its written flags, one word a cycle,
//   over all MEM_DEPTH words, with instr_stall held high.
// Receiver stall: the result register holds; the stages behind it keep
//   filling bubbles, and instr_stall rises only when all stages are full.
// ----------------------------------------------------------------------------
module rv32i_itype_execute import itx_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    instr_valid,
	output logic         instr_stall,
	input  wire instr_t  instr,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	logic                valid_s1;
	instr_t              item_s1;
	logic                valid_s2;
	ctl_s2_t             ctl_s2;
	logic                res_valid_q;
	result_t             res_q;
	logic                last_wr_q;
	logic [REG_AW-1:0]   last_rd_q;
	logic [31:0]         last_val_q;
	logic [NUM_REGS-1:0] rv_q;
	logic                clr_busy_q;
	logic [MEM_AW-1:0]   clr_addr_q;

	logic out_free, adv_s2, s2_free, adv_s1, s1_free, acc;
	logic [31:0] rf_rdata;
	logic [31:0] a_s1;
	logic [32:0] mem_rdata;
	logic [31:0] paddr32;
	logic        mem_we;
	logic [MEM_AW-1:0] mem_waddr;
	logic [32:0] mem_wdata;
	alu_out_t    alu;
	result_t     res_d;
	logic        rf_we;

	assign out_free    = !res_valid_q || !result_stall;
	assign adv_s2      = valid_s2 && out_free;
	assign s2_free     = !valid_s2 || out_free;
	assign adv_s1      = valid_s1 && s2_free;
	assign s1_free     = !valid_s1 || s2_free;
	assign instr_stall = clr_busy_q || !s1_free;
	assign acc         = instr_valid && !instr_stall;

	assign rf_we = adv_s2 && res_d.wrote_reg;

	itx_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf (
		.clk   (clk),
		.we    (rf_we),
		.waddr (res_d.written_reg),
		.wdata (res_d.written_value),
		.re    (acc),
		.raddr (instr.src_reg),
		.rdata (rf_rdata)
	);

	// rs1: in-flight commit first, then the write that raced the read, then the file
	always_comb begin
		priority if (valid_s2 && res_d.wrote_reg && res_d.written_reg == item_s1.src_reg) begin
			a_s1 = res_d.written_value;
		end else if (last_wr_q && last_rd_q == item_s1.src_reg) begin
			a_s1 = last_val_q;
		end else if (rv_q[item_s1.src_reg]) begin
			a_s1 = rf_rdata;
		end else begin
			a_s1 = 32'd0;
		end
	end

	itx_alu u_alu (
		.op  (item_s1.op),
		.a   (a_s1),
		.imm (item_s1.immediate),
		.pc  (item_s1.pc_in),
		.res (alu)
	);

	assign paddr32 = 32'(item_s1.preload_addr);

	always_comb begin
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = adv_s1 && (item_s1.op == OP_PRELOAD) && (paddr32 < 32'(MEM_DEPTH));
			mem_waddr = paddr32[MEM_AW-1:0];
			mem_wdata = {1'b1, item_s1.preload_data};
		end
	end

	itx_ram #(.WIDTH(33), .DEPTH(MEM_DEPTH)) u_dmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (adv_s1 && is_load(item_s1.op)),
		.raddr (alu.sum[MEM_AW-1:0]),
		.rdata (mem_rdata)
	);

	itx_commit u_commit (
		.ctl       (ctl_s2),
		.mem_rdata (mem_rdata),
		.res       (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
			last_wr_q   <= 1'b0;
			rv_q        <= '0;
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (rf_we) begin
				last_wr_q                <= 1'b1;
				rv_q[res_d.written_reg]  <= 1'b1;
			end
			if (clr_busy_q) begin
				if (clr_addr_q == MEM_AW'(MEM_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + MEM_AW'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= instr;
		end
		if (adv_s1) begin
			ctl_s2.op       <= item_s1.op;
			ctl_s2.rd       <= item_s1.dest_reg;
			ctl_s2.value    <= alu.value;
			ctl_s2.pc_out   <= alu.pc_next;
			ctl_s2.in_range <= alu.sum < 32'(MEM_DEPTH);
		end
		if (adv_s2) begin
			res_q <= res_d;
		end
		if (rf_we) begin
			last_rd_q  <= res_d.written_reg;
			last_val_q <= res_d.written_value;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
`default_nettype wire

>>> rtl/itx_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itx_checker
// Port-level checks of the I-type execute block, bound to the top level.
// ----------------------------------------------------------------------------
module itx_checker import itx_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    instr_stall,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	// stalled result holds until transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// no write: register and value fields are zero
	a_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.wrote_reg |->
			result.written_reg == 5'd0 && result.written_value == 32'd0)
		else $error("write fields set without a register write");

	// x0 is never reported as written
	a_x0: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.wrote_reg |-> result.written_reg != 5'd0)
		else $error("write to x0 reported");

	// data store sweep blocks input right after reset
	a_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> instr_stall)
		else $error("input taken during data store sweep");

endmodule

bind rv32i_itype_execute itx_checker u_itx_checker (.*);
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the I-type execute block against a behavioral copy of its register
// file and data store. Directed runs cover the ALU, shift, compare, load and
// jalr corner cases. Random runs mix ALU ops, preload-then-load sequences,
// jalr and stray loads, with gaps and result stalls only while idling is on.
// ----------------------------------------------------------------------------
module testbench import itx_pkg::*;;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    instr_valid  = 1'b0;
	logic    instr_stall;
	instr_t  instr        = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	rv32i_itype_execute u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_stall  (instr_stall),
		.instr        (instr),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Architectural state as the block should hold it
	logic [31:0] gpr [NUM_REGS];
	logic [31:0] dmem_word [MEM_DEPTH];
	bit          dmem_written [MEM_DEPTH];

	result_t pending_results [$];
	result_t oldest;
	int      mismatches   = 0;
	int      result_count = 0;
	bit      idle_on      = 1'b1;
	int      stall_left   = 0;

	function automatic logic [31:0] sext12(input logic [11:0] imm);
		return {{20{imm[11]}}, imm};
	endfunction

	// Apply one instruction to the state copy and return the result it must give
	function automatic result_t execute_instr(input instr_t it);
		logic [31:0] a, imm, sum, word, val;
		logic [4:0]  sh;
		logic        wr, found;
		result_t     r;
		a     = gpr[it.src_reg];
		imm   = sext12(it.immediate);
		sum   = a + imm;
		sh    = imm[4:0];
		wr    = 1'b1;
		found = 1'b0;
		word  = '0;
		val   = '0;
		r.pc_out = it.pc_in;
		if (it.op >= OP_LW && it.op <= OP_LHU && sum < 32'(MEM_DEPTH) &&
				dmem_written[sum[MEM_AW-1:0]]) begin
			found = 1'b1;
			word  = dmem_word[sum[MEM_AW-1:0]];
		end
		case (it.op)
			OP_ADDI:  val = sum;
			OP_XORI:  val = a ^ imm;
			OP_ORI:   val = a | imm;
			OP_ANDI:  val = a & imm;
			OP_SLLI:  val = a << sh;
			OP_SRLI:  val = a >> sh;
			OP_SRAI:  val = $signed(a) >>> sh;
			OP_SLTI:  val = {31'b0, $signed(a) < $signed(imm)};
			OP_SLTIU: val = {31'b0, a < imm};
			OP_LW: begin
				val = word;
				wr  = found;
			end
			OP_LB:    val = {{24{word[7]}}, word[7:0]};
			OP_LBU:   val = {24'b0, word[7:0]};
			OP_LH:    val = {{16{word[15]}}, word[15:0]};
			OP_LHU:   val = {16'b0, word[15:0]};
			OP_JALR: begin
				val      = it.pc_in;
				r.pc_out = sum - 32'd4;
			end
			default: begin
				wr = 1'b0;
				if (32'(it.preload_addr) < 32'(MEM_DEPTH)) begin
					dmem_word[it.preload_addr]    = it.preload_data;
					dmem_written[it.preload_addr] = 1'b1;
				end
			end
		endcase
		if (it.dest_reg == '0)
			wr = 1'b0;
		if (wr)
			gpr[it.dest_reg] = val;
		r.wrote_reg     = wr;
		r.written_reg   = wr ? it.dest_reg : '0;
		r.written_value = wr ? val : '0;
		r.mem_found     = found;
		return r;
	endfunction

	function automatic instr_t make_instr(input logic [3:0] op, input logic [4:0] rd,
			input logic [4:0] rs, input logic [11:0] imm);
		instr_t it;
		it.op           = op;
		it.dest_reg     = rd;
		it.src_reg      = rs;
		it.immediate    = imm;
		it.pc_in        = $urandom;
		it.preload_addr = 10'($urandom);
		it.preload_data = $urandom;
		return it;
	endfunction

	function automatic instr_t make_preload(input logic [9:0] addr, input logic [31:0] data);
		instr_t it;
		it = make_instr(OP_PRELOAD, 5'($urandom), 5'($urandom), 12'($urandom));
		it.preload_addr = addr;
		it.preload_data = data;
		return it;
	endfunction

	// Drive one instruction and hold it until the block takes it
	task automatic send_instr(input instr_t it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			instr_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		instr       <= it;
		instr_valid <= 1'b1;
		do
			@(posedge clk);
		while (instr_stall);
		pending_results.push_back(execute_instr(it));
	endtask

	// Fill an in-range load target first, so no load sees an unwritten word
	task automatic issue(input instr_t it);
		logic [31:0] sum;
		sum = gpr[it.src_reg] + sext12(it.immediate);
		if (it.op >= OP_LW && it.op <= OP_LHU && sum < 32'(MEM_DEPTH) &&
				!dmem_written[sum[MEM_AW-1:0]])
			send_instr(make_preload(sum[MEM_AW-1:0], $urandom));
		send_instr(it);
	endtask

	// Load from a chosen word, pointing a base register near it if needed
	task automatic load_from(input logic [3:0] op, input logic [4:0] rd,
			input logic [9:0] addr);
		logic [4:0]         rs;
		logic signed [31:0] offset;
		rs     = 5'($urandom_range(0, 31));
		offset = $signed({22'b0, addr} - gpr[rs]);
		if (offset < -2048 || offset > 2047) begin
			issue(make_instr(OP_ADDI, rs, 5'd0, 12'($urandom_range(0, 1023))));
			offset = $signed({22'b0, addr} - gpr[rs]);
		end
		issue(make_instr(op, rd, rs, offset[11:0]));
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d %s: expected %h, got %h", result_count, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left   <= 0;
		end else if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left   <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			result_stall <= 1'b1;
			stall_left   <= $urandom_range(0, 15);
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing outstanding: %h",
						result_count, result);
			end else begin
				oldest = pending_results.pop_front();
				check_field("wrote_reg", 32'(oldest.wrote_reg), 32'(result.wrote_reg));
				check_field("written_reg", 32'(oldest.written_reg), 32'(result.written_reg));
				check_field("written_value", oldest.written_value, result.written_value);
				check_field("pc_out", oldest.pc_out, result.pc_out);
				check_field("mem_found", 32'(oldest.mem_found), 32'(result.mem_found));
			end
			result_count++;
		end
	end

	task automatic test_alu_ops();
		issue(make_instr(OP_ADDI, 5'd14, 5'd31, 12'h000));
		issue(make_instr(OP_ADDI, 5'd1, 5'd0, 12'h7FF));
		issue(make_instr(OP_ADDI, 5'd2, 5'd0, 12'h800));
		issue(make_instr(OP_XORI, 5'd3, 5'd1, 12'hFFF));
		issue(make_instr(OP_ORI, 5'd4, 5'd1, 12'h800));
		issue(make_instr(OP_ANDI, 5'd5, 5'd4, 12'h7FF));
		issue(make_instr(OP_ADDI, 5'd0, 5'd1, 12'h001));
		issue(make_instr(OP_SLLI, 5'd6, 5'd4, 12'hFFF));
		issue(make_instr(OP_SRLI, 5'd7, 5'd6, 12'hFE1));
		issue(make_instr(OP_SRAI, 5'd8, 5'd6, 12'h01F));
		issue(make_instr(OP_SRAI, 5'd9, 5'd1, 12'h020));
		issue(make_instr(OP_SLTI, 5'd10, 5'd6, 12'h7FF));
		issue(make_instr(OP_SLTI, 5'd11, 5'd1, 12'h800));
		issue(make_instr(OP_SLTIU, 5'd12, 5'd1, 12'hFFF));
	endtask

	task automatic test_loads();
		issue(make_preload(10'd0, 32'h80FF_8081));
		issue(make_preload(10'd1023, 32'h7F7F_7F7F));
		issue(make_instr(OP_LW, 5'd15, 5'd0, 12'h000));
		issue(make_instr(OP_LB, 5'd16, 5'd0, 12'h000));
		issue(make_instr(OP_LBU, 5'd17, 5'd0, 12'h000));
		issue(make_instr(OP_LH, 5'd18, 5'd0, 12'h000));
		issue(make_instr(OP_LHU, 5'd19, 5'd0, 12'h000));
		issue(make_instr(OP_LB, 5'd21, 5'd0, 12'h3FF));
		issue(make_instr(OP_LW, 5'd0, 5'd0, 12'h3FF));
		// x2 holds -2048: both addresses wrap far past the store
		issue(make_instr(OP_LW, 5'd22, 5'd2, 12'h000));
		issue(make_instr(OP_LH, 5'd23, 5'd2, 12'h7FF));
		// x1 + imm lands exactly one past the last word
		issue(make_instr(OP_LW, 5'd24, 5'd1, 12'hC01));
	endtask

	task automatic test_jalr();
		issue(make_instr(OP_JALR, 5'd25, 5'd25, 12'h000));
		issue(make_instr(OP_JALR, 5'd25, 5'd25, 12'h7FF));
		issue(make_instr(OP_JALR, 5'd0, 5'd1, 12'h800));
	endtask

	task automatic random_item();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			issue(make_instr(4'($urandom_range(OP_ADDI, OP_SLTIU)), 5'($urandom),
				5'($urandom), 12'($urandom)));
		else if (sel < 65)
			load_from(4'($urandom_range(OP_LW, OP_LHU)), 5'($urandom),
				10'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 31) :
					$urandom_range(0, 1023)));
		else if (sel < 75)
			issue(make_preload(10'($urandom), $urandom));
		else if (sel < 85)
			issue(make_instr(OP_JALR, 5'($urandom), 5'($urandom), 12'($urandom)));
		else
			issue(make_instr(4'($urandom_range(OP_LW, OP_LHU)), 5'($urandom),
				5'($urandom), 12'($urandom)));
	endtask

	task automatic test_random_mix();
		repeat (8) begin
			// Some segments run with no idling at all
			idle_on = ($urandom_range(0, 3) != 0);
			repeat (55) random_item();
		end
	endtask

	task automatic test_streaming();
		idle_on = 1'b0;
		repeat (80) random_item();
	endtask

	initial begin
		foreach (gpr[i])
			gpr[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_alu_ops();
		test_loads();
		test_jalr();
		test_random_mix();
		test_streaming();
		instr_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2_500_000;
		$display("tb: failure");
		$finish;
	end

endmodule

>>> files.f
rtl/itx_pkg.sv
rtl/itx_ram.sv
rtl/itx_alu.sv
rtl/itx_commit.sv
rtl/rv32i_itype_execute.sv
rtl/itx_checker.sv
tb/sv/testbench.sv
